// ===== sv/frame_rate_meter_with_skip_top_defines.svh =====
// Assertion macros shared by the frame rate meter RTL.
`ifndef FRAME_RATE_METER_WITH_SKIP_TOP_DEFINES_SVH
`define FRAME_RATE_METER_WITH_SKIP_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is low.
`define FRM_AST_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame rate meter assertion failed");
// Next-cycle implication, disabled while reset is low.
`define FRM_AST_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame rate meter assertion failed");
`else
`define FRM_AST_IMPL(lbl, clk, rst_n, ante, cons)
`define FRM_AST_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/frm_pkg.sv =====
// Shared types and constants of the frame rate meter.
package frm_pkg;

    localparam int TIME_W = 32;
    localparam int INTV_W = 16;
    localparam int SUM_W  = 24;
    localparam int THR_W  = 24;
    localparam int IDX_W  = 2;

    localparam logic [THR_W-1:0] FPS_MAX = 24'hFFFFFF;

    localparam logic [IDX_W-1:0] CFG_THR_THREE = 2'd0;
    localparam logic [IDX_W-1:0] CFG_THR_TWO   = 2'd1;
    localparam logic [IDX_W-1:0] CFG_THR_ONE   = 2'd2;
    localparam logic [IDX_W-1:0] CFG_THR_HALF  = 2'd3;

    localparam logic [THR_W-1:0] THR_THREE_RST = 24'd6271;
    localparam logic [THR_W-1:0] THR_TWO_RST   = 24'd10861;
    localparam logic [THR_W-1:0] THR_ONE_RST   = 24'd21722;
    localparam logic [THR_W-1:0] THR_HALF_RST  = 24'd37624;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_UPDATE,
        S_DIV,
        S_HOLD
    } t_state;

endpackage

// ===== sv/frm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module frm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 100
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/frm_div.sv =====
// Restoring divider of a fixed dividend by a 24-bit divisor, one bit per cycle.
module frm_div #(
    parameter int NUM_W = 25,
    parameter logic [NUM_W-1:0] NUM = '0
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [frm_pkg::SUM_W-1:0] i_divisor,
    output logic                     o_done,
    output logic [NUM_W-1:0]         o_quotient
);

    localparam int CW = $clog2(NUM_W);

    logic                      r_busy;
    logic                      r_done;
    logic [CW-1:0]             r_cnt;
    logic [frm_pkg::SUM_W-1:0] r_rem;
    logic [frm_pkg::SUM_W-1:0] r_div;
    logic [NUM_W-1:0]          r_quo;
    logic [frm_pkg::SUM_W:0]   rem_sh;
    logic [frm_pkg::SUM_W:0]   rem_sub;
    logic                      fits;

    // The partial remainder stays below the divisor, so the shifted value fits 25 bits.
    always_comb begin
        rem_sh  = {r_rem, r_quo[NUM_W-1]};
        rem_sub = rem_sh - {1'b0, r_div};
        fits    = (rem_sh >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CW'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_quo <= NUM;
        end else if (r_busy) begin
            r_rem <= fits ? rem_sub[frm_pkg::SUM_W-1:0] : rem_sh[frm_pkg::SUM_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== sv/frame_rate_meter_with_skip_top.sv =====
// Top level of the moving-window frame rate meter with repeat-count decision.
//
// Usage: each input beat on the s_axis channel is one frame tick carrying a
// 32-bit millisecond timestamp. The block takes the interval since the last
// tick (0 for the first tick, saturated to 65535 ms), keeps the last WINDOW
// intervals in a ring memory with a running sum, and once the ring is full
// reports the frame rate 1000*WINDOW/sum in unsigned Q.8 together with the
// number of update steps to run for this frame. One output beat follows each
// input beat on the m_axis channel.
// Four threshold registers (index 0 to 3: thr_three, thr_two, thr_one and
// thr_half) are to be written through the plain write port while the block
// is idle; the block itself does not enforce this. Each tick passes through
// the read, update, divide and hold states on its way to the output register;
// the divide state waits for the bit-serial divider that forms the rate, with
// NUM_W the bit width of 256000*WINDOW (25 for a window of 100). A tick that
// does not fill the window skips the divide state. Ticks are processed one at
// a time: a new tick is taken only after the last one has left the hold state.
// The output register holds a finished beat until the receiver takes it;
// the next tick is accepted meanwhile and waits in its final state if the
// receiver is still stalled. Synchronous reset clears all control state and
// restores the threshold reset values; the ring memory is not cleared, since
// an entry is only read back after it has been written.
`include "frame_rate_meter_with_skip_top_defines.svh"

module frame_rate_meter_with_skip_top #(
    parameter int WINDOW = 100
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input tick channel.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] time_now_ms
    // Result channel.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [0] fps_valid, [24:1] fps_q8,
                                        // [26:25] repeat_count, [31:27] zero
    // Configuration write port.
    input  logic                        i_cfg_we,
    input  logic [frm_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [frm_pkg::THR_W-1:0]   i_cfg_wdata
);

    localparam int PW = $clog2(WINDOW);
    localparam longint NUM_VAL = 64'd256000 * WINDOW;
    localparam int NUM_W = $clog2(NUM_VAL + 1);
    localparam int QW = (NUM_W > 24) ? NUM_W : 25;

    // Threshold registers.
    logic [frm_pkg::THR_W-1:0] r_thr_three;
    logic [frm_pkg::THR_W-1:0] r_thr_two;
    logic [frm_pkg::THR_W-1:0] r_thr_one;
    logic [frm_pkg::THR_W-1:0] r_thr_half;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_three <= frm_pkg::THR_THREE_RST;
            r_thr_two   <= frm_pkg::THR_TWO_RST;
            r_thr_one   <= frm_pkg::THR_ONE_RST;
            r_thr_half  <= frm_pkg::THR_HALF_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                frm_pkg::CFG_THR_THREE: r_thr_three <= i_cfg_wdata;
                frm_pkg::CFG_THR_TWO:   r_thr_two   <= i_cfg_wdata;
                frm_pkg::CFG_THR_ONE:   r_thr_one   <= i_cfg_wdata;
                frm_pkg::CFG_THR_HALF:  r_thr_half  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Sequencer state and the meter's scalar state.
    frm_pkg::t_state r_state, n_state;
    logic [frm_pkg::TIME_W-1:0] r_now;
    logic [frm_pkg::TIME_W-1:0] r_last;
    logic                       r_seen;
    logic                       r_full;
    logic [PW-1:0]              r_pos;
    logic [frm_pkg::SUM_W-1:0]  r_sum;
    logic [2:0]                 r_skip;
    logic [frm_pkg::THR_W-1:0]  r_fps;

    // Output register.
    logic                       r_ovalid;
    logic                       r_oflag;
    logic [frm_pkg::THR_W-1:0]  r_ofps;
    logic [1:0]                 r_orep;

    logic                       in_acc;
    logic                       ram_re;
    logic                       ram_we;
    logic                       div_start;
    logic                       out_load;
    logic                       div_done;
    logic [NUM_W-1:0]           div_quo;
    logic [frm_pkg::INTV_W-1:0] ram_rdata;

    logic [frm_pkg::TIME_W-1:0] diff;
    logic [frm_pkg::INTV_W-1:0] delta;
    logic [frm_pkg::INTV_W-1:0] old;
    logic [frm_pkg::SUM_W-1:0]  n_sum;
    logic                       pos_wrap;
    logic                       n_full;
    logic [QW-1:0]              quo_ext;
    logic [frm_pkg::THR_W-1:0]  fps_sat;
    logic [2:0]                 ph;
    logic [2:0]                 ph_next;
    logic [1:0]                 rep;
    logic                       skip_step;

    assign in_acc = s_axis_tvalid && s_axis_tready;

    // Interval since the last tick; the first tick measures against itself.
    always_comb begin
        diff     = r_now - (r_seen ? r_last : r_now);
        delta    = (|diff[frm_pkg::TIME_W-1:frm_pkg::INTV_W]) ? '1 : diff[frm_pkg::INTV_W-1:0];
        old      = r_full ? ram_rdata : '0;
        n_sum    = r_sum + frm_pkg::SUM_W'(delta) - frm_pkg::SUM_W'(old);
        pos_wrap = (r_pos == PW'(WINDOW - 1));
        n_full   = r_full || pos_wrap;
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            frm_pkg::S_IDLE:   if (s_axis_tvalid) n_state = frm_pkg::S_READ;
            frm_pkg::S_READ:   n_state = frm_pkg::S_UPDATE;
            frm_pkg::S_UPDATE: n_state = n_full ? frm_pkg::S_DIV : frm_pkg::S_HOLD;
            frm_pkg::S_DIV:    if (div_done) n_state = frm_pkg::S_HOLD;
            frm_pkg::S_HOLD:   if (!r_ovalid || m_axis_tready) n_state = frm_pkg::S_IDLE;
            default:           n_state = frm_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        s_axis_tready = 1'b0;
        ram_re        = 1'b0;
        ram_we        = 1'b0;
        div_start     = 1'b0;
        out_load      = 1'b0;
        case (r_state)
            frm_pkg::S_IDLE:   s_axis_tready = 1'b1;
            frm_pkg::S_READ:   ram_re = 1'b1;
            frm_pkg::S_UPDATE: begin
                ram_we    = 1'b1;
                div_start = n_full;
            end
            frm_pkg::S_DIV:    ;
            frm_pkg::S_HOLD:   out_load = !r_ovalid || m_axis_tready;
            default: ;
        endcase
    end

    // Ring of intervals; the read in S_READ lands in time for the update.
    frm_ram #(
        .WIDTH (frm_pkg::INTV_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_pos),
        .i_wdata (delta),
        .i_re    (ram_re),
        .i_raddr (r_pos),
        .o_rdata (ram_rdata)
    );

    frm_div #(
        .NUM_W (NUM_W),
        .NUM   (NUM_W'(NUM_VAL))
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_divisor  (n_sum),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Rate saturation, including a zero sum, then the repeat-count bands.
    always_comb begin
        quo_ext   = QW'(div_quo);
        fps_sat   = (r_sum == '0 || quo_ext > QW'(frm_pkg::FPS_MAX)) ? frm_pkg::FPS_MAX
                                                                     : quo_ext[23:0];
        ph        = (r_skip >= 3'd6) ? r_skip - 3'd6 : r_skip;
        ph_next   = (ph == 3'd5) ? 3'd0 : ph + 3'd1;
        skip_step = 1'b0;
        if (!r_full) begin
            rep = 2'd1;
        end else if (r_fps < r_thr_three) begin
            rep = 2'd3;
        end else if (r_fps < r_thr_two) begin
            rep = 2'd2;
        end else if (r_fps < r_thr_one) begin
            rep = 2'd1;
        end else if (r_fps < r_thr_half) begin
            rep       = {1'b0, ~ph[0]};
            skip_step = 1'b1;
        end else begin
            rep       = {1'b0, (ph == 3'd0 || ph == 3'd3)};
            skip_step = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= frm_pkg::S_IDLE;
            r_seen   <= 1'b0;
            r_full   <= 1'b0;
            r_pos    <= '0;
            r_sum    <= '0;
            r_last   <= '0;
            r_skip   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (ram_we) begin
                r_seen <= 1'b1;
                r_full <= n_full;
                r_pos  <= pos_wrap ? '0 : r_pos + PW'(1);
                r_sum  <= n_sum;
                r_last <= r_now;
            end
            if (out_load && skip_step) begin
                r_skip <= ph_next;
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_now <= s_axis_tdata;
        end
        if (ram_we) begin
            r_fps <= '0;
        end else if (div_done) begin
            r_fps <= fps_sat;
        end
        if (out_load) begin
            r_oflag <= r_full;
            r_ofps  <= r_fps;
            r_orep  <= rep;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {5'd0, r_orep, r_ofps, r_oflag};

    `FRM_AST_IMPL(a_skip_range, i_clk, i_rst_n, 1'b1, r_skip < 3'd6)
    `FRM_AST_IMPL(a_pos_range, i_clk, i_rst_n, 1'b1, r_pos <= PW'(WINDOW - 1))
    `FRM_AST_NEXT(a_full_sticky, i_clk, i_rst_n, r_full, r_full)
    `FRM_AST_IMPL(a_div_in_seq, i_clk, i_rst_n, div_done, r_state == frm_pkg::S_DIV)

endmodule
